// ----- hdl/lznt1_pkg.sv -----
// ----------------------------------------------------------------------------
// lznt1_pkg: shared types and constants
// Payload structs, parse states and status codes for the LZNT1 decompressor.
// ----------------------------------------------------------------------------
package lznt1_pkg;

  localparam int unsigned BLOCK_BYTES_DEF = 4096;
  localparam int unsigned HIST_AW = 12;
  localparam logic [4:0] CLUSTER_LOG2_RST = 5'd12;

  typedef enum logic [1:0] {
    CMD_BYTE = 2'd0,
    CMD_TICK = 2'd1,
    CMD_END  = 2'd2,
    CMD_NOP  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    PS_HDR_LO = 3'd0,
    PS_HDR_HI = 3'd1,
    PS_FLAG   = 3'd2,
    PS_SYM    = 3'd3,
    PS_PHR_LO = 3'd4,
    PS_PHR_HI = 3'd5,
    PS_SKIP   = 3'd6,
    PS_BAD    = 3'd7
  } pstate_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_UNCOMP  = 3'd1,
    ST_BADREF  = 3'd2,
    ST_OVERFL  = 3'd3,
    ST_BYTECPY = 3'd4,
    ST_TRUNC   = 3'd5
  } status_t;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic       copy_pending;
    logic [2:0] status;
  } out_item_t;

  // history memory request from the parser
  typedef struct packed {
    logic              rd_en;
    logic [HIST_AW-1:0] rd_addr;
    logic              wr_en;
    logic [HIST_AW-1:0] wr_addr;
    logic [7:0]        wr_data;
  } hist_req_t;

endpackage

// ----- hdl/lznt1_hist.sv -----
// ----------------------------------------------------------------------------
// lznt1_hist: history memory
// 4096 x 8 synchronous ram, one write and one registered read per cycle,
// with write-to-read forwarding for same-cycle collisions.
// ----------------------------------------------------------------------------
module lznt1_hist (
  input  logic                 clk,
  input  lznt1_pkg::hist_req_t req,
  output logic [7:0]           rd_data
);
  localparam int unsigned DEPTH = 1 << lznt1_pkg::HIST_AW;

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) mem[req.wr_addr] <= req.wr_data;
    if (req.rd_en) begin
      if (req.wr_en && req.wr_addr == req.rd_addr) rd_r <= req.wr_data;
      else rd_r <= mem[req.rd_addr];
    end
  end

  assign rd_data = rd_r;
endmodule

// ----- hdl/lznt1_parse.sv -----
// ----------------------------------------------------------------------------
// lznt1_parse: stream parser and copy engine
// Parses headers, flags and tokens; runs back-reference copies through the
// history memory; produces one result per accepted request.
// ----------------------------------------------------------------------------
module lznt1_parse #(
  parameter int unsigned BLOCK_BYTES = lznt1_pkg::BLOCK_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  go,
  input  lznt1_pkg::in_item_t   item,
  input  logic [4:0]            cluster_log2,
  output lznt1_pkg::hist_req_t  hreq,
  input  logic [7:0]            hist_rd,
  output lznt1_pkg::out_item_t  res,
  output logic                  res_hist
);
  localparam int unsigned AW = lznt1_pkg::HIST_AW;
  localparam logic [13:0] BLK = 14'(BLOCK_BYTES);

  lznt1_pkg::pstate_t ps_r, ps_nxt;
  logic [12:0] left_r, left_nxt;
  logic [12:0] pos_r, pos_nxt;
  logic [7:0]  flag_r, flag_nxt;
  logic [3:0]  tidx_r, tidx_nxt;
  logic [7:0]  hlo_r, hlo_nxt;
  logic [15:0] ipos_r, ipos_nxt;
  logic [AW-1:0] src_r, src_nxt;
  logic [12:0] rem_r, rem_nxt;
  lznt1_pkg::status_t err_r, err_nxt;

  // result byte and its valid flag
  logic [7:0] ob;
  logic ov;

  logic [15:0] hdr;
  logic [3:0]  sh;
  logic [12:0] pm1;
  logic [16:0] ret;
  logic [12:0] len;
  logic [15:0] mask;
  logic [4:0]  k;

  // advance to the next token; operates on already-updated fields
  function automatic void nt(input logic [12:0] left, input logic [12:0] pos,
                             input logic [7:0] fl, inout logic [3:0] ti,
                             inout lznt1_pkg::pstate_t ps,
                             inout lznt1_pkg::status_t er,
                             inout logic [12:0] rm);
    if (left == 13'd0) ps = lznt1_pkg::PS_HDR_LO;
    else if (14'(pos) >= BLK) begin
      er = lznt1_pkg::ST_OVERFL; rm = '0;
    end else if (ti >= 4'd8) ps = lznt1_pkg::PS_FLAG;
    else begin
      ps = fl[ti[2:0]] ? lznt1_pkg::PS_PHR_LO : lznt1_pkg::PS_SYM;
      ti = ti + 4'd1;
    end
  endfunction

  always_comb begin
    ps_nxt = ps_r; left_nxt = left_r; pos_nxt = pos_r; flag_nxt = flag_r;
    tidx_nxt = tidx_r; hlo_nxt = hlo_r; ipos_nxt = ipos_r; src_nxt = src_r;
    rem_nxt = rem_r; err_nxt = err_r;
    hreq = '0; ob = '0; ov = 1'b0; res_hist = 1'b0;
    hdr = {item.data_byte, hlo_r};
    pm1 = pos_r - 13'd1;
    sh = '0;
    if (pm1 >= 13'd16) sh = 4'd1;
    if (pm1 >= 13'd32) sh = 4'd2;
    if (pm1 >= 13'd64) sh = 4'd3;
    if (pm1 >= 13'd128) sh = 4'd4;
    if (pm1 >= 13'd256) sh = 4'd5;
    if (pm1 >= 13'd512) sh = 4'd6;
    if (pm1 >= 13'd1024) sh = 4'd7;
    if (pm1 >= 13'd2048) sh = 4'd8;
    if (pm1 >= 13'd4096) sh = 4'd9;
    ret = 17'(hdr >> (4'd12 - sh)) + 17'd1;
    len = 13'(hdr & (16'h0fff >> sh)) + 13'd3;
    k = (cluster_log2 > 5'd16) ? 5'd16 : cluster_log2;
    mask = 16'((17'd1 << k) - 17'd1);
    if (go && err_r == lznt1_pkg::ST_OK) begin
      case (lznt1_pkg::cmd_t'(item.command))
        lznt1_pkg::CMD_BYTE: begin
          if (rem_r != 13'd0) begin
            err_nxt = lznt1_pkg::ST_BYTECPY; rem_nxt = '0;
          end else begin
            ipos_nxt = ipos_r + 16'd1;
            if (ps_r inside {lznt1_pkg::PS_FLAG, lznt1_pkg::PS_SYM,
                             lznt1_pkg::PS_PHR_LO, lznt1_pkg::PS_PHR_HI})
              left_nxt = left_r - 13'd1;
            case (ps_r)
              lznt1_pkg::PS_HDR_LO: begin
                hlo_nxt = item.data_byte; ps_nxt = lznt1_pkg::PS_HDR_HI;
              end
              lznt1_pkg::PS_HDR_HI: begin
                if (hdr == 16'd0) ps_nxt = lznt1_pkg::PS_SKIP;
                else if (!hdr[15]) err_nxt = lznt1_pkg::ST_UNCOMP;
                else begin
                  left_nxt = {1'b0, hdr[11:0]} + 13'd1;
                  pos_nxt = '0; ps_nxt = lznt1_pkg::PS_FLAG;
                end
              end
              lznt1_pkg::PS_FLAG: begin
                flag_nxt = item.data_byte; tidx_nxt = '0;
                nt(left_nxt, pos_r, item.data_byte, tidx_nxt, ps_nxt, err_nxt,
                   rem_nxt);
              end
              lznt1_pkg::PS_SYM: begin
                hreq.wr_en = 1'b1; hreq.wr_addr = pos_r[AW-1:0];
                hreq.wr_data = item.data_byte;
                pos_nxt = pos_r + 13'd1;
                ob = item.data_byte; ov = 1'b1;
                nt(left_nxt, pos_nxt, flag_r, tidx_nxt, ps_nxt, err_nxt, rem_nxt);
              end
              lznt1_pkg::PS_PHR_LO: begin
                hlo_nxt = item.data_byte; ps_nxt = lznt1_pkg::PS_PHR_HI;
              end
              lznt1_pkg::PS_PHR_HI: begin
                if (pos_r == 13'd0) err_nxt = lznt1_pkg::ST_BADREF;
                else if (ret > 17'(pos_r)) err_nxt = lznt1_pkg::ST_BADREF;
                else if (14'(pos_r) + 14'(len) > BLK) err_nxt = lznt1_pkg::ST_OVERFL;
                else begin
                  src_nxt = AW'(pos_r - 13'(ret));
                  rem_nxt = len;
                  // prefetch first copy byte
                  hreq.rd_en = 1'b1; hreq.rd_addr = src_nxt;
                end
              end
              lznt1_pkg::PS_SKIP: begin
                if ((ipos_nxt & mask) == mask) ps_nxt = lznt1_pkg::PS_HDR_LO;
              end
              default: ps_nxt = lznt1_pkg::PS_HDR_LO;
            endcase
          end
        end
        lznt1_pkg::CMD_TICK: begin
          if (rem_r != 13'd0) begin
            // data for src_r is in hist_rd (prefetched by the phrase byte or the previous tick)
            res_hist = 1'b1; ov = 1'b1;
            hreq.wr_en = 1'b1; hreq.wr_addr = pos_r[AW-1:0];
            hreq.wr_data = hist_rd;
            pos_nxt = pos_r + 13'd1;
            src_nxt = src_r + AW'(1);
            rem_nxt = rem_r - 13'd1;
            hreq.rd_en = 1'b1; hreq.rd_addr = src_nxt;
            if (rem_nxt == 13'd0)
              nt(left_r, pos_nxt, flag_r, tidx_nxt, ps_nxt, err_nxt, rem_nxt);
          end
        end
        lznt1_pkg::CMD_END: begin
          if (rem_r != 13'd0 || (ps_r != lznt1_pkg::PS_HDR_LO &&
                                 ps_r != lznt1_pkg::PS_SKIP)) begin
            err_nxt = lznt1_pkg::ST_TRUNC; rem_nxt = '0;
          end
        end
        default: ;
      endcase
    end
    res.out_byte = ob;
    res.out_valid = ov;
    res.copy_pending = (rem_nxt != 13'd0);
    res.status = err_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ps_r <= lznt1_pkg::PS_HDR_LO; left_r <= '0; pos_r <= '0; flag_r <= '0;
      tidx_r <= '0; hlo_r <= '0; ipos_r <= 16'hffff; src_r <= '0; rem_r <= '0;
      err_r <= lznt1_pkg::ST_OK;
    end else begin
      ps_r <= ps_nxt; left_r <= left_nxt; pos_r <= pos_nxt; flag_r <= flag_nxt;
      tidx_r <= tidx_nxt; hlo_r <= hlo_nxt; ipos_r <= ipos_nxt; src_r <= src_nxt;
      rem_r <= rem_nxt; err_r <= err_nxt;
    end
  end
endmodule

// ----- hdl/lznt1_stream_decompressor.sv -----
// ----------------------------------------------------------------------------
// lznt1_stream_decompressor: LZNT1 stream decompressor top level
// Byte-serial parser around a 4 KiB history ram with a registered output.
//
//  channel | direction | payload            | handshake
//  in_     | in        | in_item_t          | in_valid / in_ready
//  out_    | out       | out_item_t         | out_valid / out_ready
//  cfg_    | in        | cluster_size_log2  | apb psel/penable/pwrite
//
// one request per cycle sustained while out_ is not stalled; every request yields one result
// a copy byte is read from the history ahead of its tick (prefetched on the
// phrase byte or the previous tick) so the ram port keeps up with that rate
// a stall on out_ holds the result register; in_ready follows it
// reset (rst_n low, synchronous) clears parse state, errors and the output
// ----------------------------------------------------------------------------
module lznt1_stream_decompressor #(
  parameter int unsigned BLOCK_BYTES = lznt1_pkg::BLOCK_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  lznt1_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output lznt1_pkg::out_item_t out_data,
  input  logic                 cfg_psel,
  input  logic                 cfg_penable,
  input  logic                 cfg_pwrite,
  input  logic [0:0]           cfg_paddr,
  input  logic [31:0]          cfg_pwdata,
  output logic [31:0]          cfg_prdata,
  output logic                 cfg_pready
);
  logic [4:0] clog2_r;
  lznt1_pkg::hist_req_t hreq;
  logic [7:0] hist_rd;
  lznt1_pkg::out_item_t res, res_r;
  logic res_hist, go, ov_r;

  // output register: free or being drained
  assign in_ready = !ov_r || out_ready;
  assign go = in_valid && in_ready;

  // configuration register
  assign cfg_pready = 1'b1;
  assign cfg_prdata = {27'd0, clog2_r};
  always_ff @(posedge clk) begin
    if (!rst_n) clog2_r <= lznt1_pkg::CLUSTER_LOG2_RST;
    else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == 1'b0)
      clog2_r <= cfg_pwdata[4:0];
  end

  lznt1_hist u_hist (.clk(clk), .req(hreq), .rd_data(hist_rd));

  lznt1_parse #(.BLOCK_BYTES(BLOCK_BYTES)) u_parse (
    .clk(clk), .rst_n(rst_n), .go(go), .item(in_data), .cluster_log2(clog2_r),
    .hreq(hreq), .hist_rd(hist_rd), .res(res), .res_hist(res_hist)
  );

  // result register; copy bytes come straight from the ram output
  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (go) ov_r <= 1'b1;
    else if (out_ready) ov_r <= 1'b0;
    if (go) begin
      res_r <= res;
      if (res_hist) res_r.out_byte <= hist_rd;
    end
  end

  assign out_valid = ov_r;
  assign out_data = res_r;

  // result register never overwritten while held
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> ($stable(out_data) && out_valid))
    else $error("result changed while stalled");
  // a request always produces a result next cycle
  a_res: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> out_valid)
    else $error("missing result");
  // once an error was reported, later results carry no byte
  a_err: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status != lznt1_pkg::ST_OK &&
     $past(out_data.status) != lznt1_pkg::ST_OK &&
     $past(out_valid && out_ready)) |-> !out_data.out_valid)
    else $error("output byte after sticky error");
endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for lznt1_stream_decompressor
// Builds well-formed compressed chunks (literals, overlapping phrases, zero
// headers with cluster padding, idle ticks, no-ops) and ends on one randomly
// chosen error case. A scoreboard predicts every result and checks each one.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int BLOCK = int'(lznt1_pkg::BLOCK_BYTES_DEF);

  // ---------------------------------------------------------------------
  // scoreboard: decoder state copy and the queue of expected results
  // ---------------------------------------------------------------------
  class lznt1_scoreboard;
    logic [7:0]  hist [0:4095];
    lznt1_pkg::pstate_t ps;
    logic [12:0] left;
    logic [12:0] opos;
    logic [7:0]  flags;
    logic [3:0]  tidx;
    logic [7:0]  hlo;
    logic [15:0] ipos;
    logic [11:0] csrc;
    logic [12:0] crem;
    lznt1_pkg::status_t err;
    logic [4:0]  clog;
    lznt1_pkg::out_item_t exp_q[$];
    int          n_req;
    int          n_lit;
    int          n_copy;

    function new();
      foreach (hist[i]) hist[i] = '0;
      ps = lznt1_pkg::PS_HDR_LO;
      left = '0;
      opos = '0;
      flags = '0;
      tidx = '0;
      hlo = '0;
      ipos = 16'hffff;
      csrc = '0;
      crem = '0;
      err = lznt1_pkg::ST_OK;
      clog = lznt1_pkg::CLUSTER_LOG2_RST;
      n_req = 0;
      n_lit = 0;
      n_copy = 0;
    endfunction

    function void set_error(lznt1_pkg::status_t c);
      err = c;
      crem = '0;
    endfunction

    function void next_token();
      logic b;
      if (left == 0) begin
        ps = lznt1_pkg::PS_HDR_LO;
      end else if (opos >= BLOCK) begin
        set_error(lznt1_pkg::ST_OVERFL);
      end else if (tidx >= 8) begin
        ps = lznt1_pkg::PS_FLAG;
      end else begin
        b = flags[tidx[2:0]];
        tidx = tidx + 4'd1;
        ps = b ? lznt1_pkg::PS_PHR_LO : lznt1_pkg::PS_SYM;
      end
    endfunction

    function void open_phrase(logic [15:0] ph);
      int sh, i, ret, len;
      if (opos == 0) begin
        set_error(lznt1_pkg::ST_BADREF);
        return;
      end
      sh = 0;
      i = int'(opos) - 1;
      while (i >= 16) begin
        sh++;
        i = i >> 1;
      end
      ret = (int'(ph) >> (12 - sh)) + 1;
      len = (int'(ph) & (32'hfff >> sh)) + 3;
      if (ret > int'(opos)) set_error(lznt1_pkg::ST_BADREF);
      else if (int'(opos) + len > BLOCK) set_error(lznt1_pkg::ST_OVERFL);
      else begin
        csrc = 12'(int'(opos) - ret);
        crem = 13'(len);
      end
    endfunction

    function void note_request(lznt1_pkg::in_item_t it);
      lznt1_pkg::out_item_t e;
      int k, msk;
      logic [15:0] hdr;
      logic [7:0] v;
      e = '0;
      n_req++;
      if (err != lznt1_pkg::ST_OK) begin
        // sticky error, nothing moves
      end else if (it.command == lznt1_pkg::CMD_BYTE) begin
        if (crem != 0) begin
          set_error(lznt1_pkg::ST_BYTECPY);
        end else begin
          ipos = ipos + 16'd1;
          case (ps)
            lznt1_pkg::PS_HDR_LO: begin
              hlo = it.data_byte;
              ps = lznt1_pkg::PS_HDR_HI;
            end
            lznt1_pkg::PS_HDR_HI: begin
              hdr = {it.data_byte, hlo};
              if (hdr == 0) ps = lznt1_pkg::PS_SKIP;
              else if (!hdr[15]) set_error(lznt1_pkg::ST_UNCOMP);
              else begin
                left = {1'b0, hdr[11:0]} + 13'd1;
                opos = '0;
                ps = lznt1_pkg::PS_FLAG;
              end
            end
            lznt1_pkg::PS_FLAG: begin
              left = left - 13'd1;
              flags = it.data_byte;
              tidx = '0;
              next_token();
            end
            lznt1_pkg::PS_SYM: begin
              left = left - 13'd1;
              hist[opos[11:0]] = it.data_byte;
              opos = opos + 13'd1;
              e.out_byte = it.data_byte;
              e.out_valid = 1'b1;
              n_lit++;
              next_token();
            end
            lznt1_pkg::PS_PHR_LO: begin
              left = left - 13'd1;
              hlo = it.data_byte;
              ps = lznt1_pkg::PS_PHR_HI;
            end
            lznt1_pkg::PS_PHR_HI: begin
              left = left - 13'd1;
              open_phrase({it.data_byte, hlo});
            end
            lznt1_pkg::PS_SKIP: begin
              k = (clog > 16) ? 16 : int'(clog);
              msk = (1 << k) - 1;
              if ((int'(ipos) & msk) == msk) ps = lznt1_pkg::PS_HDR_LO;
            end
            default: ps = lznt1_pkg::PS_HDR_LO;
          endcase
        end
      end else if (it.command == lznt1_pkg::CMD_TICK) begin
        if (crem != 0) begin
          v = hist[csrc];
          hist[opos[11:0]] = v;
          opos = opos + 13'd1;
          csrc = csrc + 12'd1;
          crem = crem - 13'd1;
          e.out_byte = v;
          e.out_valid = 1'b1;
          n_copy++;
          if (crem == 0) next_token();
        end
      end else if (it.command == lznt1_pkg::CMD_END) begin
        if (crem != 0 || (ps != lznt1_pkg::PS_HDR_LO && ps != lznt1_pkg::PS_SKIP))
          set_error(lznt1_pkg::ST_TRUNC);
      end
      e.copy_pending = (crem != 0);
      e.status = err;
      exp_q.push_back(e);
    endfunction

    function string check_result(lznt1_pkg::out_item_t got);
      lznt1_pkg::out_item_t e;
      string s;
      if (exp_q.size() == 0) return "result arrived with no request pending";
      e = exp_q.pop_front();
      s = "";
      if (got.out_byte !== e.out_byte)
        s = {s, $sformatf(" out_byte %h/%h", got.out_byte, e.out_byte)};
      if (got.out_valid !== e.out_valid)
        s = {s, $sformatf(" out_valid %b/%b", got.out_valid, e.out_valid)};
      if (got.copy_pending !== e.copy_pending)
        s = {s, $sformatf(" copy_pending %b/%b", got.copy_pending, e.copy_pending)};
      if (got.status !== e.status)
        s = {s, $sformatf(" status %0d/%0d", got.status, e.status)};
      if (s != "") s = {"got/exp:", s};
      return s;
    endfunction
  endclass

  // ---------------------------------------------------------------------
  // signals
  // ---------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  lznt1_pkg::in_item_t  in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  lznt1_pkg::out_item_t out_data;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [0:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  lznt1_scoreboard sb;
  lznt1_pkg::in_item_t stim_q[$];  // requests waiting to be driven
  logic [15:0] gen_ipos;     // generator's view of the input byte index
  int        n_errors = 0;
  int        hold_cycles = 0;  // long receiver hold-off, counted in its process
  int        final_case;
  string     msg;

  lznt1_stream_decompressor u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // hard stop in case the block hangs
  initial begin
    #2000000;
    $display("** lznt1_stream_decompressor: FAILED **");
    $finish;
  end

  task automatic report_mismatch(input string s);
    n_errors++;
    $display("[%0t] mismatch: %s", $realtime, s);
  endtask

  // monitor: note accepted requests, check accepted results
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_request(in_data);
      if (out_valid && out_ready) begin
        msg = sb.check_result(out_data);
        if (msg != "") report_mismatch(msg);
      end
    end
  end

  // receiver: random stall pattern, plus the long hold-off when asked
  initial begin : receiver
    int mode, mode_left;
    mode = 0;
    mode_left = 0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_ready <= 1'b0;
        hold_cycles = hold_cycles - 1;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 2);
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          default: out_ready <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------
  // stimulus building
  // ---------------------------------------------------------------------
  function automatic lznt1_pkg::in_item_t mk(lznt1_pkg::cmd_t c, logic [7:0] b);
    lznt1_pkg::in_item_t it;
    it.command = c;
    it.data_byte = b;
    return it;
  endfunction

  function automatic void push_byte(logic [7:0] b);
    stim_q.push_back(mk(lznt1_pkg::CMD_BYTE, b));
    gen_ipos = gen_ipos + 16'd1;
  endfunction

  // one compressed chunk of target output bytes, parser sits at header low
  function automatic void gen_chunk(int target, bit big);
    lznt1_pkg::in_item_t body[$];
    int opos, nb, fidx, t, sh, i, maxret, ret, lmax, len;
    logic [7:0] flag;
    logic [15:0] ph, hdr;
    opos = 0;
    nb = 0;
    while (opos < target) begin
      fidx = body.size();
      body.push_back(mk(lznt1_pkg::CMD_BYTE, 8'h00));
      nb++;
      flag = '0;
      for (t = 0; t < 8 && opos < target; t++) begin
        if (opos > 0 && target - opos >= 3 && $urandom_range(0, 2) == 0) begin
          // phrase: offset/length split follows the position
          sh = 0;
          i = opos - 1;
          while (i >= 16) begin
            sh++;
            i = i >> 1;
          end
          maxret = (opos < (1 << (4 + sh))) ? opos : (1 << (4 + sh));
          ret = ($urandom_range(0, 3) == 0) ? maxret : int'($urandom_range(1, maxret));
          lmax = (4095 >> sh) + 3;
          if (lmax > target - opos) lmax = target - opos;
          if (!big && lmax > 27) lmax = 27;
          len = $urandom_range(3, lmax);
          ph = 16'(((ret - 1) << (12 - sh)) | (len - 3));
          flag[t] = 1'b1;
          body.push_back(mk(lznt1_pkg::CMD_BYTE, ph[7:0]));
          body.push_back(mk(lznt1_pkg::CMD_BYTE, ph[15:8]));
          nb += 2;
          repeat (len) body.push_back(mk(lznt1_pkg::CMD_TICK, 8'($urandom)));
          opos += len;
        end else begin
          body.push_back(mk(lznt1_pkg::CMD_BYTE, 8'($urandom)));
          nb++;
          opos++;
        end
        if ($urandom_range(0, 15) == 0)
          body.push_back(mk(lznt1_pkg::CMD_NOP, 8'($urandom)));
      end
      // flag bits past the chunk end are don't-care
      body[fidx].data_byte = flag | 8'($urandom & ~((1 << t) - 1));
    end
    hdr = 16'h8000 | 16'($urandom & 32'h7000) | 16'(nb - 1);
    push_byte(hdr[7:0]);
    push_byte(hdr[15:8]);
    foreach (body[j]) begin
      if (body[j].command == lznt1_pkg::CMD_BYTE) push_byte(body[j].data_byte);
      else stim_q.push_back(body[j]);
    end
  endfunction

  // zero header, then padding up to the cluster boundary
  function automatic void gen_skip(logic [4:0] clog);
    int k, msk;
    k = (clog > 16) ? 16 : int'(clog);
    msk = (1 << k) - 1;
    push_byte(8'h00);
    push_byte(8'h00);
    do push_byte(8'($urandom)); while ((int'(gen_ipos) & msk) != msk);
  endfunction

  // harmless items between chunks
  function automatic void gen_noise();
    repeat ($urandom_range(1, 3)) begin
      case ($urandom_range(0, 2))
        0: stim_q.push_back(mk(lznt1_pkg::CMD_NOP, 8'($urandom)));
        1: stim_q.push_back(mk(lznt1_pkg::CMD_TICK, 8'($urandom)));
        default: stim_q.push_back(mk(lznt1_pkg::CMD_END, 8'($urandom)));
      endcase
    end
  endfunction

  // closing error case; the error is sticky so it comes last
  function automatic void gen_error_tail(int kind);
    case (kind)
      0: begin  // uncompressed chunk header
        push_byte(8'h34); push_byte(8'h12);
      end
      1: begin  // phrase with no history
        push_byte(8'h02); push_byte(8'h80);
        push_byte(8'h01); push_byte(8'h00); push_byte(8'h00);
      end
      2: begin  // offset reaching before chunk start
        push_byte(8'h04); push_byte(8'h80);
        push_byte(8'h04); push_byte(8'($urandom)); push_byte(8'($urandom));
        push_byte(8'h00); push_byte(8'h40);
      end
      3: begin  // copy running past the block
        push_byte(8'h03); push_byte(8'h80);
        push_byte(8'h02); push_byte(8'($urandom));
        push_byte(8'hfd); push_byte(8'h0f);
      end
      4: begin  // byte while a copy is pending
        push_byte(8'h03); push_byte(8'h80);
        push_byte(8'h02); push_byte(8'($urandom));
        push_byte(8'h02); push_byte(8'h00);
        repeat (2) stim_q.push_back(mk(lznt1_pkg::CMD_TICK, 8'($urandom)));
        push_byte(8'($urandom));
      end
      default: begin  // header cuts a phrase, then a truncated end
        push_byte(8'h02); push_byte(8'h80);
        push_byte(8'h02); push_byte(8'($urandom));
        push_byte(8'h01); push_byte(8'h00);
        repeat ($urandom_range(0, 1) ? 4 : 2)
          stim_q.push_back(mk(lznt1_pkg::CMD_TICK, 8'($urandom)));
        stim_q.push_back(mk(lznt1_pkg::CMD_END, 8'($urandom)));
      end
    endcase
    repeat (20)
      stim_q.push_back(mk(lznt1_pkg::cmd_t'(2'($urandom_range(0, 3))), 8'($urandom)));
  endfunction

  // ---------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------
  task automatic drive_requests();
    lznt1_pkg::in_item_t it;
    int burst_left, gap;
    burst_left = 0;
    while (stim_q.size() != 0) begin
      it = stim_q.pop_front();
      gap = 0;
      if (burst_left == 0) begin
        burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(100, 300)
                                               : $urandom_range(1, 30);
        gap = $urandom_range(1, 6);
      end
      burst_left--;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_valid <= 1'b1;
      in_data <= it;
      do @(posedge clk); while (!in_ready);
    end
    in_valid <= 1'b0;
  endtask

  // wait until every expected result has come, plus the output latency
  task automatic drain();
    do @(posedge clk); while (sb.exp_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [4:0] v);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= '0;
    cfg_pwdata <= {27'd0, v};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    sb.clog = v;
  endtask

  // ---------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------
  initial begin : main
    logic [4:0] phase_clog [0:5];
    int p;
    sb = new();
    gen_ipos = 16'hffff;
    phase_clog[0] = 5'd9;
    phase_clog[1] = 5'd16;
    phase_clog[2] = 5'd12;
    phase_clog[3] = 5'($urandom_range(9, 16));
    phase_clog[4] = 5'd9;
    phase_clog[5] = 5'd16;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: clean end, idle tick, no-op, small chunk, long copies
    stim_q.push_back(mk(lznt1_pkg::CMD_END, 8'hff));
    stim_q.push_back(mk(lznt1_pkg::CMD_TICK, 8'h00));
    stim_q.push_back(mk(lznt1_pkg::CMD_NOP, 8'haa));
    gen_chunk(20, 1'b0);
    gen_chunk(300, 1'b1);
    gen_chunk(8, 1'b0);
    drive_requests();

    // random phases, each after writing its cluster size
    for (p = 0; p < 6; p++) begin
      drain();
      cfg_write(phase_clog[p]);
      if (p == 1) hold_cycles = 400;  // input must back up while out_ stalls
      while (stim_q.size() < 230) begin
        case ($urandom_range(0, 9))
          0: if (sb.clog <= 9) gen_skip(sb.clog); else gen_noise();
          1: gen_noise();
          2: gen_chunk($urandom_range(100, 300), 1'($urandom_range(0, 1)));
          default: gen_chunk($urandom_range(1, 60), 1'b0);
        endcase
      end
      drive_requests();
    end

    drain();
    final_case = $urandom_range(0, 5);
    gen_error_tail(final_case);
    drive_requests();
    drain();
    repeat (10) @(posedge clk);

    while (sb.exp_q.size() != 0) begin
      void'(sb.exp_q.pop_front());
      report_mismatch("expected result never arrived");
    end
    $display("covered %0d requests: %0d literal and %0d copied bytes out",
             sb.n_req, sb.n_lit, sb.n_copy);
    $display("closing error case %0d, final status %0d, %0d mismatches",
             final_case, sb.err, n_errors);
    if (n_errors == 0) begin
      $display("** lznt1_stream_decompressor: PASSED **");
    end else begin
      $display("** lznt1_stream_decompressor: FAILED **");
    end
    $finish;
  end

endmodule
